// ----- rtl/assert_macros.svh -----
// assertion macros shared by the residual stencil rtl
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/psr_pkg.sv -----
// shared types and constants of the poisson residual stencil
// no dependencies; imported by psr_lines, psr_calc and the top level
package psr_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned GridW      = 11;
  localparam int unsigned MaxSideDef = 1024;
  localparam int unsigned LapW       = DataW + 4;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // operand window of one interior point
  typedef struct packed {
    logic signed [DataW-1:0] up;
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] centre;
    logic signed [DataW-1:0] right;
    logic signed [DataW-1:0] down;
    logic signed [DataW-1:0] f_val;
  } stencil_t;

endpackage

// ----- rtl/poisson_residual_stencil.sv -----
// poisson residual stencil: five-point laplacian defect over a raster-order grid
// an accepted item passes the b, c, d and e registers; e holds the output
// throughput: one item per cycle, set by the line stores taking one read and one
// write per cycle each; the pipe stalls only while a full output is not taken
// reset: counters clear, grid_size returns to 1024; line stores are not cleared
// depends on psr_pkg, psr_lines, psr_calc and assert_macros.svh
`include "assert_macros.svh"

module poisson_residual_stencil #(
  parameter int unsigned MAX_SIDE = psr_pkg::MaxSideDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // u_value [31:0], f_value [63:32]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((psr_pkg::DataW + 2 * $clog2(MAX_SIDE) + 7) / 8) * 8 - 1:0]
                      m_axis_tdata,   // residual, row_index, col_index, zero pad
  output logic        m_axis_tlast    // last_point
);
  import psr_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_SIDE);
  localparam int unsigned SideW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned ScaleW = 2 * IdxW;
  localparam int unsigned CmpW   = (GridW > SideW) ? GridW : SideW;
  localparam int unsigned TdW    = ((DataW + 2 * IdxW + 7) / 8) * 8;
  localparam int unsigned MinSide  = 3;
  localparam int unsigned GridRst  = 1024;
  localparam int unsigned RstSide  = (GridRst > MAX_SIDE) ? MAX_SIDE : GridRst;
  localparam int unsigned RstScale = (RstSide - 1) * (RstSide - 1);
  localparam logic        RegGrid  = 1'b0;

  logic [GridW-1:0]  grid_q;
  logic [SideW-1:0]  side_q, side_d;
  logic [ScaleW-1:0] scale_q, scale_d;
  logic [IdxW-1:0]   row_q, col_q;
  logic [IdxW-1:0]   side_m1;
  logic [CmpW-1:0]   grid_ext;
  logic              grid_wr;
  logic              s_acc;
  logic              col_end, row_end, emit, last_pt;
  logic              calc_ready;
  stencil_t          win;
  logic signed [DataW-1:0] residual;
  logic [IdxW-1:0]   out_row, out_col;

  assign pready  = 1'b1;
  assign grid_wr = psel && penable && pwrite && pready && (paddr[2] == RegGrid);
  assign prdata  = (paddr[2] == RegGrid) ? 32'(grid_q) : '0;

  // clamp the written size to the supported range
  always_comb begin
    grid_ext = CmpW'(pwdata[GridW-1:0]);
    if (grid_ext < CmpW'(MinSide)) begin
      side_d = SideW'(MinSide);
    end else if (grid_ext > CmpW'(MAX_SIDE)) begin
      side_d = SideW'(MAX_SIDE);
    end else begin
      side_d = SideW'(grid_ext);
    end
    side_m1 = IdxW'(side_d - SideW'(1));
    scale_d = ScaleW'(side_m1) * ScaleW'(side_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= GridW'(GridRst);
      side_q  <= SideW'(RstSide);
      scale_q <= ScaleW'(RstScale);
    end else if (grid_wr) begin
      grid_q  <= pwdata[GridW-1:0];
      side_q  <= side_d;
      scale_q <= scale_d;
    end
  end

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign col_end = SideW'(col_q) == side_q - SideW'(1);
  assign row_end = SideW'(row_q) == side_q - SideW'(1);
  assign emit    = (row_q >= IdxW'(2)) && (col_q >= IdxW'(1))
                && (SideW'(col_q) <= side_q - SideW'(2));
  assign last_pt = row_end && (SideW'(col_q) == side_q - SideW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (grid_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (s_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + IdxW'(1);
      end else begin
        col_q <= col_q + IdxW'(1);
      end
    end
  end

  assign s_axis_tready = calc_ready;

  psr_lines #(
    .MAX_SIDE (MAX_SIDE)
  ) u_lines (
    .clk_i      (clk_i),
    .acc_i      (s_acc),
    .col_i      (col_q),
    .col_wrap_i (col_end),
    .u_i        (s_axis_tdata[DataW-1:0]),
    .f_i        (s_axis_tdata[2*DataW-1:DataW]),
    .win_o      (win)
  );

  psr_calc #(
    .MAX_SIDE (MAX_SIDE)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && emit),
    .in_ready_o  (calc_ready),
    .row_i       (row_q - IdxW'(1)),
    .col_i       (col_q),
    .last_i      (last_pt),
    .win_i       (win),
    .scale_i     (scale_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .residual_o  (residual),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TdW'({out_col, out_row, residual});

  `ASSERT_PROP(a_col_range, clk_i, rst_ni, SideW'(col_q) < side_q)
  `ASSERT_PROP(a_row_range, clk_i, rst_ni, SideW'(row_q) < side_q)

endmodule

// ----- rtl/psr_lines.sv -----
// line stores for u (two rows) and f (one row) with registered reads
// depends on psr_pkg; delivers the stencil window in the cycle after an item is taken
module psr_lines #(
  parameter int unsigned MAX_SIDE = psr_pkg::MaxSideDef,
  localparam int unsigned IdxW = $clog2(MAX_SIDE)
) (
  input  logic                       clk_i,
  input  logic                       acc_i,
  input  logic [IdxW-1:0]            col_i,
  input  logic                       col_wrap_i,
  input  logic [psr_pkg::DataW-1:0]  u_i,
  input  logic [psr_pkg::DataW-1:0]  f_i,
  output psr_pkg::stencil_t          win_o
);
  import psr_pkg::*;

  logic [DataW-1:0] older_mem [MAX_SIDE];
  logic [DataW-1:0] newer_mem [MAX_SIDE];
  logic [DataW-1:0] f_mem     [MAX_SIDE];

  logic [DataW-1:0] older_rd_q;
  logic [DataW-1:0] newer_rd_q;
  logic [DataW-1:0] f_rd_q;
  logic [DataW-1:0] down_q;
  logic [DataW-1:0] cen_q;
  logic [DataW-1:0] left_q;
  logic [IdxW-1:0]  nxt_col;

  // look one column ahead, wrapping at the grid edge
  assign nxt_col = col_wrap_i ? '0 : col_i + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      older_rd_q       <= older_mem[col_i];
      older_mem[col_i] <= newer_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      newer_rd_q       <= newer_mem[nxt_col];
      newer_mem[col_i] <= u_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      f_rd_q       <= f_mem[col_i];
      f_mem[col_i] <= f_i;
    end
  end

  // the incoming u becomes down; earlier look-ahead reads become centre and left
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      down_q <= u_i;
      cen_q  <= newer_rd_q;
      left_q <= cen_q;
    end
  end

  assign win_o.up     = $signed(older_rd_q);
  assign win_o.left   = $signed(left_q);
  assign win_o.centre = $signed(cen_q);
  assign win_o.right  = $signed(newer_rd_q);
  assign win_o.down   = $signed(down_q);
  assign win_o.f_val  = $signed(f_rd_q);

endmodule

// ----- rtl/psr_calc.sv -----
// laplacian, scaling and saturation pipeline with per-stage valids
// depends on psr_pkg and assert_macros.svh; fed by psr_lines
`include "assert_macros.svh"

module psr_calc #(
  parameter int unsigned MAX_SIDE = psr_pkg::MaxSideDef,
  localparam int unsigned IdxW = $clog2(MAX_SIDE),
  localparam int unsigned ScaleW = 2 * IdxW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [IdxW-1:0]                   row_i,
  input  logic [IdxW-1:0]                   col_i,
  input  logic                              last_i,
  input  psr_pkg::stencil_t                 win_i,
  input  logic [ScaleW-1:0]                 scale_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [psr_pkg::DataW-1:0]  residual_o,
  output logic [IdxW-1:0]                   out_row_o,
  output logic [IdxW-1:0]                   out_col_o,
  output logic                              out_last_o
);
  import psr_pkg::*;

  localparam int unsigned ProdW = LapW + ScaleW + 1;
  localparam int unsigned DiffW = ProdW + 1;

  logic b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic c_rdy, d_rdy, e_rdy;

  logic [IdxW-1:0] b_row_q, c_row_q, d_row_q, e_row_q;
  logic [IdxW-1:0] b_col_q, c_col_q, d_col_q, e_col_q;
  logic            b_last_q, c_last_q, d_last_q, e_last_q;

  logic signed [LapW-1:0]  lap_d, c_lap_q;
  logic signed [DataW-1:0] c_f_q, d_f_q;
  logic signed [ProdW-1:0] prod_d, d_prod_q;
  logic signed [DiffW-1:0] diff;
  logic signed [DataW-1:0] sat_d, e_res_q;

  assign e_rdy      = !e_vld_q || out_ready_i;
  assign d_rdy      = !d_vld_q || e_rdy;
  assign c_rdy      = !c_vld_q || d_rdy;
  assign in_ready_o = !b_vld_q || c_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        b_vld_q <= in_valid_i;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
      end
      if (d_rdy) begin
        d_vld_q <= c_vld_q;
      end
      if (e_rdy) begin
        e_vld_q <= d_vld_q;
      end
    end
  end

  // 4u minus the four neighbours
  always_comb begin
    lap_d = (LapW'($signed(win_i.centre)) <<< 2)
          - LapW'($signed(win_i.up))
          - LapW'($signed(win_i.left))
          - LapW'($signed(win_i.right))
          - LapW'($signed(win_i.down));
  end

  assign prod_d = $signed(c_lap_q) * $signed({1'b0, scale_i});

  always_comb begin
    diff = DiffW'($signed(d_f_q)) - DiffW'($signed(d_prod_q));
    if (!diff[DiffW-1] && (|diff[DiffW-2:DataW-1])) begin
      sat_d = SatMax;
    end else if (diff[DiffW-1] && !(&diff[DiffW-2:DataW-1])) begin
      sat_d = SatMin;
    end else begin
      sat_d = $signed(diff[DataW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      b_row_q  <= row_i;
      b_col_q  <= col_i;
      b_last_q <= last_i;
    end
    if (c_rdy && b_vld_q) begin
      c_lap_q  <= lap_d;
      c_f_q    <= win_i.f_val;
      c_row_q  <= b_row_q;
      c_col_q  <= b_col_q;
      c_last_q <= b_last_q;
    end
    if (d_rdy && c_vld_q) begin
      d_prod_q <= prod_d;
      d_f_q    <= c_f_q;
      d_row_q  <= c_row_q;
      d_col_q  <= c_col_q;
      d_last_q <= c_last_q;
    end
    if (e_rdy && d_vld_q) begin
      e_res_q  <= sat_d;
      e_row_q  <= d_row_q;
      e_col_q  <= d_col_q;
      e_last_q <= d_last_q;
    end
  end

  assign out_valid_o = e_vld_q;
  assign residual_o  = e_res_q;
  assign out_row_o   = e_row_q;
  assign out_col_o   = e_col_q;
  assign out_last_o  = e_last_q;

  `ASSERT_NEXT(a_take_item, clk_i, rst_ni, in_valid_i && in_ready_o, b_vld_q)
  `ASSERT_NEXT(a_b_hold, clk_i, rst_ni, b_vld_q && !c_rdy, b_vld_q && $stable(b_row_q))
  `ASSERT_PROP(a_last_diag, clk_i, rst_ni, !(out_valid_o && out_last_o) || (out_row_o == out_col_o))

endmodule
